>>> src/hsm_pkg.sv
package hsm_pkg;

    localparam int BINS     = 256;
    localparam int BIN_AW   = 8;
    localparam int AGE_W    = 5;
    localparam int THR_W    = 16;
    localparam int LIM_W    = 4;
    localparam int IDX_W    = 4;
    localparam int OCNT_W   = 5;

    localparam logic [THR_W-1:0]  THR_RST   = 16'd62948;
    localparam logic [LIM_W-1:0]  LIM_RST   = 4'd5;
    localparam logic [BIN_AW-1:0] PIX_SKIP  = 8'd255;
    localparam logic [AGE_W-1:0]  AGE_MATCH = 5'd31;
    localparam logic [AGE_W-1:0]  AGE_NEW   = 5'd0;

    localparam logic REG_THR = 1'b0;
    localparam logic REG_LIM = 1'b1;

    typedef struct packed {
        logic              action;
        logic [7:0]        pixel;
        logic              last;
    } hsm_req_t;

    typedef struct packed {
        logic              matched;
        logic [IDX_W-1:0]  match_index;
        logic              stored_new;
        logic              dropped;
        logic [OCNT_W-1:0] removed_count;
        logic [OCNT_W-1:0] entry_count;
    } hsm_rsp_t;

    typedef struct packed {
        logic              vld;
        logic [BIN_AW-1:0] addr;
    } hsm_strm_t;

    typedef struct packed {
        logic              clr;
        logic              wr_mode;
        logic              tick;
        logic              age_set;
        logic [AGE_W-1:0]  age_val;
    } hsm_ctl_t;

endpackage

>>> src/histogram_signature_match_table.sv
// Channel  Direction  Handshake                    Payload
// req      in         req_valid / req_ready        hsm_req_t (action, pixel, last)
// rsp      out        rsp_valid / rsp_ready        hsm_rsp_t (one per lookup or tick)
// apb      in/out     psel, penable, pwrite, pready  cos_sq_threshold @0, age_limit @4
//
// A pixel request reads the histogram RAM, then writes the bin back.
// A lookup streams the crop histogram through the cells, then tests entries in order
// on the shared digit-serial multiplier, ND = (2*BIN_BITS+15)/8 digits of b.
// A tick ages every entry, rotates the order chain, then runs an odd-even sort.
// Reset clears control state; signature RAMs and ages stay undefined until written.
// A new result waits in its final state while the previous rsp is stalled;
// req_ready is low meanwhile.
module histogram_signature_match_table
    import hsm_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int BIN_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  hsm_req_t    req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output hsm_rsp_t    rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ACC_W    = 2 * BIN_BITS + 8;
    localparam int MP_W     = 3 * ACC_W;
    localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int STRM_LEN = BINS + ENTRIES + 4;
    localparam int SC_W     = $clog2(STRM_LEN + 1);
    localparam logic [BIN_BITS-1:0] BIN_MAX = {BIN_BITS{1'b1}};

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PIX   = 4'd1;
    localparam logic [3:0] ST_STRM  = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_M1    = 4'd4;
    localparam logic [3:0] ST_M2    = 4'd5;
    localparam logic [3:0] ST_M3    = 4'd6;
    localparam logic [3:0] ST_DEC   = 4'd7;
    localparam logic [3:0] ST_TAGE  = 4'd8;
    localparam logic [3:0] ST_TROT  = 4'd9;
    localparam logic [3:0] ST_TSORT = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    logic [3:0]          state_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [LIM_W-1:0]    lim_reg;
    logic [BIN_AW-1:0]   pix_reg;
    logic                last_reg;
    logic [BINS-1:0]     hv_reg;
    logic [SC_W-1:0]     sc_reg;
    logic                wr_pass_reg;
    logic                fin_lk_reg;
    logic                s_vld_reg;
    logic [BIN_AW-1:0]   s_addr_reg;
    logic [2*BIN_BITS-1:0] nhp_reg;
    logic                nhv_reg;
    logic [ACC_W-1:0]    nh_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    kept_reg;
    logic [CNT_W-1:0]    rm_reg;
    logic                found_reg;
    logic [SLOT_W-1:0]   tgt_reg;
    logic [SLOT_W-1:0]   free_reg;
    logic [AGE_W-1:0]    age_val_reg;
    logic [SLOT_W-1:0]   ord_reg [ENTRIES];
    logic [ENTRIES-1:0]  keep_reg;
    logic                mst_reg;
    logic [2*ACC_W-1:0]  ma_reg;
    logic [ACC_W-1:0]    mb_reg;
    logic [MP_W-1:0]     lhs_reg;
    hsm_rsp_t            res_reg;
    hsm_rsp_t            rsp_reg;
    logic                rsp_valid_reg;

    logic [BIN_BITS-1:0] hist_rdata;
    logic [BIN_BITS-1:0] cur;
    logic [BIN_BITS-1:0] sbin;
    logic                hist_we;
    logic                mdone;
    logic [MP_W-1:0]     mp;
    logic                test_needed;
    logic                rot;
    logic                keep_head;
    logic                live_head;
    logic                fin_load;
    logic [SLOT_W-1:0]   head;
    hsm_ctl_t            ctl;
    hsm_strm_t           s_chain [ENTRIES+1];
    logic [BIN_BITS-1:0] b_chain [ENTRIES+1];
    logic [ACC_W-1:0]    dot_w [ENTRIES];
    logic [ACC_W-1:0]    ns_w [ENTRIES];
    logic [ENTRIES-1:0]  age_hit;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_LIM) ? 32'(lim_reg) : 32'(thr_reg);
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cur     = hv_reg[pix_reg] ? hist_rdata : '0;
    assign sbin    = hv_reg[s_addr_reg] ? hist_rdata : '0;
    assign hist_we = (state_reg == ST_PIX) && (pix_reg != PIX_SKIP) && (cur != BIN_MAX);

    hsm_ram #(
        .WIDTH (BIN_BITS),
        .DEPTH (BINS)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (pix_reg),
        .wdata (cur + 1'b1),
        .raddr ((state_reg == ST_IDLE) ? req.pixel : sc_reg[BIN_AW-1:0]),
        .rdata (hist_rdata)
    );

    assign ctl.clr     = (state_reg == ST_STRM) && !wr_pass_reg && (sc_reg == '0);
    assign ctl.wr_mode = wr_pass_reg;
    assign ctl.tick    = (state_reg == ST_TAGE);
    assign ctl.age_set = (state_reg == ST_STRM) && wr_pass_reg && (sc_reg == '0);
    assign ctl.age_val = age_val_reg;

    assign s_chain[0].vld  = s_vld_reg;
    assign s_chain[0].addr = s_addr_reg;
    assign b_chain[0]      = sbin;

    for (genvar j = 0; j < ENTRIES; j++)
    begin : g_cell
        hsm_cell #(
            .BIN_BITS (BIN_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .sel     (tgt_reg == SLOT_W'(j)),
            .limit   (lim_reg),
            .s_in    (s_chain[j]),
            .bin_in  (b_chain[j]),
            .s_out   (s_chain[j+1]),
            .bin_out (b_chain[j+1]),
            .dot     (dot_w[j]),
            .ns      (ns_w[j]),
            .age_hit (age_hit[j])
        );
    end

    hsm_mul #(
        .AW (2 * ACC_W),
        .BW (ACC_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mst_reg),
        .a     (ma_reg),
        .b     (mb_reg),
        .done  (mdone),
        .p     (mp)
    );

    assign head        = ord_reg[0];
    assign live_head   = (k_reg < count_reg);
    assign test_needed = live_head && !found_reg;
    assign keep_head   = live_head && !age_hit[head];
    assign rot         = ((state_reg == ST_SCAN) && !test_needed)
                       || ((state_reg == ST_M3) && mdone)
                       || (state_reg == ST_TROT);
    assign fin_load    = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RST;
            lim_reg <= LIM_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_THR)
            begin
                thr_reg <= pwdata[THR_W-1:0];
            end
            else
            begin
                lim_reg <= pwdata[LIM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= '0;
        end
        else if (fin_load && fin_lk_reg)
        begin
            hv_reg <= '0;
        end
        else if (hist_we)
        begin
            hv_reg[pix_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg <= 1'b0;
            nhv_reg   <= 1'b0;
        end
        else
        begin
            s_vld_reg <= (state_reg == ST_STRM) && (sc_reg < SC_W'(BINS));
            nhv_reg   <= s_vld_reg && !wr_pass_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_addr_reg <= sc_reg[BIN_AW-1:0];
        nhp_reg    <= sbin * sbin;
        if (ctl.clr)
        begin
            nh_reg <= '0;
        end
        else if (nhv_reg)
        begin
            nh_reg <= nh_reg + ACC_W'(nhp_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                ord_reg[j] <= SLOT_W'(j);
            end
            keep_reg <= '0;
        end
        else if (rot)
        begin
            for (int j = 0; j < ENTRIES - 1; j++)
            begin
                ord_reg[j]  <= ord_reg[j+1];
                keep_reg[j] <= keep_reg[j+1];
            end
            ord_reg[ENTRIES-1]  <= ord_reg[0];
            keep_reg[ENTRIES-1] <= (state_reg == ST_TROT) ? keep_head : keep_reg[0];
        end
        else if (state_reg == ST_TSORT)
        begin
            for (int j = 0; j < ENTRIES - 1; j++)
            begin
                if ((((j % 2) == 1) == k_reg[0]) && !keep_reg[j] && keep_reg[j+1])
                begin
                    ord_reg[j]    <= ord_reg[j+1];
                    ord_reg[j+1]  <= ord_reg[j];
                    keep_reg[j]   <= 1'b1;
                    keep_reg[j+1] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sc_reg        <= '0;
            wr_pass_reg   <= 1'b0;
            fin_lk_reg    <= 1'b0;
            count_reg     <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            rm_reg        <= '0;
            found_reg     <= 1'b0;
            tgt_reg       <= '0;
            free_reg      <= '0;
            age_val_reg   <= AGE_NEW;
            mst_reg       <= 1'b0;
            res_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            mst_reg <= ((state_reg == ST_SCAN) && test_needed)
                     || (((state_reg == ST_M1) || (state_reg == ST_M2)) && mdone);
            if (fin_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= req.action ? ST_TAGE : ST_PIX;
                    end
                end
                ST_PIX:
                begin
                    if (last_reg)
                    begin
                        state_reg   <= ST_STRM;
                        sc_reg      <= '0;
                        wr_pass_reg <= 1'b0;
                        fin_lk_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_STRM:
                begin
                    if (sc_reg == SC_W'(STRM_LEN - 1))
                    begin
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= wr_pass_reg ? ST_FIN : ST_SCAN;
                    end
                    else
                    begin
                        sc_reg <= sc_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (test_needed)
                    begin
                        ma_reg    <= (2*ACC_W)'(dot_w[head]);
                        mb_reg    <= dot_w[head];
                        state_reg <= ST_M1;
                    end
                    else
                    begin
                        if (k_reg == count_reg)
                        begin
                            free_reg <= head;
                        end
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg == CNT_W'(ENTRIES - 1)) ? ST_DEC : ST_SCAN;
                    end
                end
                ST_M1:
                begin
                    if (mdone)
                    begin
                        lhs_reg   <= mp << THR_W;
                        ma_reg    <= (2*ACC_W)'(ns_w[head]);
                        mb_reg    <= nh_reg;
                        state_reg <= ST_M2;
                    end
                end
                ST_M2:
                begin
                    if (mdone)
                    begin
                        ma_reg    <= mp[2*ACC_W-1:0];
                        mb_reg    <= ACC_W'(thr_reg);
                        state_reg <= ST_M3;
                    end
                end
                ST_M3:
                begin
                    if (mdone)
                    begin
                        if ((lhs_reg >= mp) && (ns_w[head] != '0) && (nh_reg != '0))
                        begin
                            found_reg <= 1'b1;
                            idx_reg   <= k_reg;
                            tgt_reg   <= head;
                        end
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg == CNT_W'(ENTRIES - 1)) ? ST_DEC : ST_SCAN;
                    end
                end
                ST_DEC:
                begin
                    sc_reg <= '0;
                    if (found_reg)
                    begin
                        res_reg <= '{matched: 1'b1, match_index: IDX_W'(idx_reg),
                                     stored_new: 1'b0, dropped: 1'b0, removed_count: '0,
                                     entry_count: OCNT_W'(count_reg)};
                        age_val_reg <= AGE_MATCH;
                        wr_pass_reg <= 1'b1;
                        state_reg   <= ST_STRM;
                    end
                    else if (count_reg < CNT_W'(ENTRIES))
                    begin
                        res_reg <= '{matched: 1'b0, match_index: IDX_W'(count_reg),
                                     stored_new: 1'b1, dropped: 1'b0, removed_count: '0,
                                     entry_count: OCNT_W'(count_reg + 1'b1)};
                        count_reg   <= count_reg + 1'b1;
                        tgt_reg     <= free_reg;
                        age_val_reg <= AGE_NEW;
                        wr_pass_reg <= 1'b1;
                        state_reg   <= ST_STRM;
                    end
                    else
                    begin
                        res_reg <= '{matched: 1'b0, match_index: '0,
                                     stored_new: 1'b0, dropped: 1'b1, removed_count: '0,
                                     entry_count: OCNT_W'(count_reg)};
                        state_reg <= ST_FIN;
                    end
                end
                ST_TAGE:
                begin
                    k_reg      <= '0;
                    kept_reg   <= '0;
                    rm_reg     <= '0;
                    fin_lk_reg <= 1'b0;
                    state_reg  <= ST_TROT;
                end
                ST_TROT:
                begin
                    kept_reg <= kept_reg + CNT_W'(keep_head);
                    rm_reg   <= rm_reg + CNT_W'(live_head && age_hit[head]);
                    if (k_reg == CNT_W'(ENTRIES - 1))
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_TSORT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_TSORT:
                begin
                    if (k_reg == CNT_W'(ENTRIES - 1))
                    begin
                        count_reg <= kept_reg;
                        res_reg   <= '{matched: 1'b0, match_index: '0,
                                       stored_new: 1'b0, dropped: 1'b0,
                                       removed_count: OCNT_W'(rm_reg),
                                       entry_count: OCNT_W'(kept_reg)};
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_FIN:
                begin
                    if (fin_load)
                    begin
                        wr_pass_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            pix_reg  <= req.pixel;
            last_reg <= req.last;
        end
        if (fin_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    a_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mdone |-> (state_reg == ST_M1 || state_reg == ST_M2 || state_reg == ST_M3))
        else $error("multiplier finished outside a similarity test");

    a_hist_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_load && fin_lk_reg) |=> (hv_reg == '0))
        else $error("crop histogram not cleared after lookup");

    a_sort_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TSORT) |=> ($countones(keep_reg) == $past($countones(keep_reg))))
        else $error("order sort changed the number of kept entries");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

endmodule

>>> src/hsm_ram.sv
module hsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/hsm_mul.sv
module hsm_mul #(
    parameter int AW = 80,
    parameter int BW = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] p
);

    localparam int PW  = AW + BW;
    localparam int ND  = (BW + 7) / 8;
    localparam int BWP = ND * 8;
    localparam int CW  = $clog2(ND + 1);

    logic [PW-1:0]  m_reg;
    logic [BWP-1:0] b_reg;
    logic [PW-1:0]  acc_reg;
    logic [CW-1:0]  cnt_reg;
    logic           done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(ND);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // one 8-bit digit of b per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg   <= PW'(a);
            b_reg   <= BWP'(b);
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_reg + m_reg * PW'(b_reg[7:0]);
            m_reg   <= m_reg << 8;
            b_reg   <= b_reg >> 8;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

>>> src/hsm_cell.sv
module hsm_cell
    import hsm_pkg::*;
#(
    parameter int BIN_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hsm_ctl_t                ctl,
    input  logic                    sel,
    input  logic [LIM_W-1:0]        limit,
    input  hsm_strm_t               s_in,
    input  logic [BIN_BITS-1:0]     bin_in,
    output hsm_strm_t               s_out,
    output logic [BIN_BITS-1:0]     bin_out,
    output logic [2*BIN_BITS+7:0]   dot,
    output logic [2*BIN_BITS+7:0]   ns,
    output logic                    age_hit
);

    localparam int ACC_W = 2 * BIN_BITS + 8;
    localparam int PRD_W = 2 * BIN_BITS;

    hsm_strm_t           s1_reg;
    logic [BIN_BITS-1:0] b1_reg;
    logic [BIN_BITS-1:0] sig_rdata;
    logic                v2_reg;
    logic [PRD_W-1:0]    pd_reg;
    logic [PRD_W-1:0]    pn_reg;
    logic [ACC_W-1:0]    dot_reg;
    logic [ACC_W-1:0]    ns_reg;
    logic [AGE_W-1:0]    age_reg;

    hsm_ram #(
        .WIDTH (BIN_BITS),
        .DEPTH (BINS)
    ) u_sig (
        .clk   (clk),
        .we    (s_in.vld && ctl.wr_mode && sel),
        .waddr (s_in.addr),
        .wdata (bin_in),
        .raddr (s_in.addr),
        .rdata (sig_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            v2_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= s_in;
            v2_reg <= s1_reg.vld && !ctl.wr_mode;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg <= bin_in;
        pd_reg <= sig_rdata * b1_reg;
        pn_reg <= sig_rdata * sig_rdata;
        if (ctl.clr)
        begin
            dot_reg <= '0;
            ns_reg  <= '0;
        end
        else if (v2_reg)
        begin
            dot_reg <= dot_reg + ACC_W'(pd_reg);
            ns_reg  <= ns_reg + ACC_W'(pn_reg);
        end
        if (ctl.tick)
        begin
            age_reg <= age_reg + 1'b1;
        end
        else if (ctl.age_set && sel)
        begin
            age_reg <= ctl.age_val;
        end
    end

    assign s_out   = s1_reg;
    assign bin_out = b1_reg;
    assign dot     = dot_reg;
    assign ns      = ns_reg;
    assign age_hit = (age_reg == AGE_W'(limit));

endmodule

>>> test/histogram_signature_match_table_test.sv
`timescale 1ns / 1ps

module histogram_signature_match_table_test
    import hsm_pkg::*;
();

    localparam int NUM_ENTRIES = 16;
    localparam int BIN_W       = 16;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 40;
    localparam int EXP_DEPTH   = 16;
    localparam logic [BIN_W-1:0] BIN_FULL = '1;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    hsm_req_t    req;
    logic        rsp_valid;
    logic        rsp_ready;
    hsm_rsp_t    rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    histogram_signature_match_table #(
        .ENTRIES  (NUM_ENTRIES),
        .BIN_BITS (BIN_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    logic [BIN_W-1:0] crop_bins [BINS];
    logic [BIN_W-1:0] sig_bins  [NUM_ENTRIES][BINS];
    logic [AGE_W-1:0] sig_age   [NUM_ENTRIES];
    int               sig_count;
    logic [THR_W-1:0] thr_cfg;
    logic [LIM_W-1:0] lim_cfg;

    hsm_rsp_t exp_fifo [EXP_DEPTH];
    int       exp_wr;
    int       exp_rd;
    int       errors;
    int       burst_left;
    int       idle_cycles;
    int       stall_mode;
    int       stall_left;
    logic [7:0] palette [6][6];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit hist_similar(int e);
        logic [63:0]  dot;
        logic [63:0]  ns;
        logic [63:0]  nh;
        logic [127:0] lhs;
        logic [127:0] rhs;
        dot = '0;
        ns  = '0;
        nh  = '0;
        for (int b = 0; b < BINS; b++)
        begin
            dot += 64'(sig_bins[e][b]) * 64'(crop_bins[b]);
            ns  += 64'(sig_bins[e][b]) * 64'(sig_bins[e][b]);
            nh  += 64'(crop_bins[b]) * 64'(crop_bins[b]);
        end
        if (ns == 0 || nh == 0)
            return 1'b0;
        lhs = (128'(dot) * 128'(dot)) << 16;
        rhs = 128'(ns) * 128'(nh) * 128'(thr_cfg);
        return lhs >= rhs;
    endfunction

    function automatic bit table_step(hsm_req_t r, output hsm_rsp_t res);
        int kept;
        logic [AGE_W-1:0] a;
        res = '0;
        if (r.action)
        begin
            kept = 0;
            for (int i = 0; i < sig_count; i++)
            begin
                a = sig_age[i] + 1'b1;
                if (a == AGE_W'(lim_cfg))
                begin
                    res.removed_count++;
                end
                else
                begin
                    sig_bins[kept] = sig_bins[i];
                    sig_age[kept]  = a;
                    kept++;
                end
            end
            sig_count = kept;
        end
        else
        begin
            if (r.pixel != PIX_SKIP && crop_bins[r.pixel] != BIN_FULL)
                crop_bins[r.pixel]++;
            if (!r.last)
                return 1'b0;
            for (int i = 0; i < sig_count; i++)
            begin
                if (hist_similar(i))
                begin
                    sig_bins[i]     = crop_bins;
                    sig_age[i]      = AGE_MATCH;
                    res.matched     = 1'b1;
                    res.match_index = IDX_W'(i);
                    break;
                end
            end
            if (!res.matched)
            begin
                if (sig_count < NUM_ENTRIES)
                begin
                    sig_bins[sig_count] = crop_bins;
                    sig_age[sig_count]  = AGE_NEW;
                    res.match_index     = IDX_W'(sig_count);
                    res.stored_new      = 1'b1;
                    sig_count++;
                end
                else
                begin
                    res.dropped = 1'b1;
                end
            end
            for (int b = 0; b < BINS; b++)
                crop_bins[b] = '0;
        end
        res.entry_count = OCNT_W'(sig_count);
        return 1'b1;
    endfunction

    task automatic send_request(logic action, logic [7:0] pixel, logic last);
        int gap;
        hsm_rsp_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req <= '{action: action, pixel: pixel, last: last};
        do @(posedge clk); while (!req_ready);
        if (table_step('{action: action, pixel: pixel, last: last}, res))
        begin
            exp_fifo[exp_wr % EXP_DEPTH] = res;
            exp_wr++;
        end
    endtask

    task automatic hold_requests();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        hold_requests();
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(logic sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (sel == REG_THR)
            thr_cfg = value[THR_W-1:0];
        else
            lim_cfg = value[LIM_W-1:0];
    endtask

    task automatic set_config(logic [THR_W-1:0] thr, logic [LIM_W-1:0] lim);
        drain();
        apb_write(REG_THR, 32'(thr));
        apb_write(REG_LIM, 32'(lim));
    endtask

    task automatic send_crop(int n, logic [7:0] pixel);
        for (int i = 0; i < n; i++)
            send_request(1'b0, pixel, i == n - 1);
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        hsm_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (exp_rd == exp_wr)
            begin
                report_mismatch("unexpected response", 1, 0);
            end
            else
            begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (rsp.matched !== want.matched)
                    report_mismatch("matched", rsp.matched, want.matched);
                if (rsp.match_index !== want.match_index)
                    report_mismatch("match_index", rsp.match_index, want.match_index);
                if (rsp.stored_new !== want.stored_new)
                    report_mismatch("stored_new", rsp.stored_new, want.stored_new);
                if (rsp.dropped !== want.dropped)
                    report_mismatch("dropped", rsp.dropped, want.dropped);
                if (rsp.removed_count !== want.removed_count)
                    report_mismatch("removed_count", rsp.removed_count, want.removed_count);
                if (rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", rsp.entry_count, want.entry_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 300);
        end
        stall_left--;
        case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 9) == 0);
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("histogram_signature_match_table_test NOT OK");
            $finish;
        end
    end

    task automatic test_empty_and_zero_norm();
        send_request(1'b1, 8'hA5, 1'b1);
        send_crop(1, 8'd0);
        send_crop(1, 8'd255);
        send_crop(1, 8'd0);
        send_request(1'b0, 8'd3, 1'b0);
        send_request(1'b0, 8'd255, 1'b1);
        send_request(1'b1, 8'h5A, 1'b0);
    endtask

    task automatic test_fill_and_drop();
        for (int i = 1; i <= NUM_ENTRIES + 1; i++)
            send_crop(2, 8'(i * 13));
        send_crop(3, 8'd13);
    endtask

    task automatic test_ageing();
        for (int i = 0; i < 6; i++)
            send_request(1'b1, 8'(i), 1'(i));
    endtask

    task automatic test_random(int n);
        int k;
        int len;
        for (int i = 0; i < n; )
        begin
            k = $urandom_range(0, 99);
            if (k < 10)
            begin
                send_request(1'b1, 8'($urandom), 1'($urandom));
                i++;
            end
            else if (k < 20)
            begin
                len = $urandom_range(1, 8);
                for (int p = 0; p < len; p++)
                    send_request(1'b0, 8'($urandom), p == len - 1);
                i += len;
            end
            else
            begin
                k = $urandom_range(0, 5);
                len = $urandom_range(1, 12);
                for (int p = 0; p < len; p++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(1'b0, 8'($urandom), p == len - 1);
                    else
                        send_request(1'b0, palette[k][$urandom_range(0, 5)], p == len - 1);
                end
                i += len;
            end
        end
    endtask

    task automatic test_config_sweep();
        set_config(THR_RST, LIM_RST);
        test_random(350);
        set_config('0, 4'd1);
        test_random(350);
        set_config('1, 4'd15);
        test_random(350);
        set_config(THR_W'($urandom), LIM_W'($urandom_range(1, 15)));
        test_random(350);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        rsp_ready  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        errors     = 0;
        exp_wr     = 0;
        exp_rd     = 0;
        burst_left = 0;
        idle_cycles = 0;
        stall_left = 0;
        sig_count  = 0;
        thr_cfg    = THR_RST;
        lim_cfg    = LIM_RST;
        for (int b = 0; b < BINS; b++)
            crop_bins[b] = '0;
        for (int k = 0; k < 6; k++)
            for (int j = 0; j < 6; j++)
                palette[k][j] = 8'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_zero_norm();
        test_fill_and_drop();
        test_ageing();
        set_config(THR_RST, 4'd1);
        test_empty_and_zero_norm();
        test_ageing();
        test_config_sweep();

        drain();
        if (errors == 0)
            $display("histogram_signature_match_table_test OK");
        else
            $display("histogram_signature_match_table_test NOT OK");
        $finish;
    end

endmodule
